### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU key-value store.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int KEY_BITS = 32;
   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;    // latch request, clear scan trackers
      logic rd_en;    // read entry at scan index, advance index
      logic finish;   // commit write-back and load result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_rd;  // scan index is at the last entry
      logic out_free; // result register can take a new transaction
   } sts_type;

endpackage

### hw/rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Request sequencer: accept, scan all entries, drain read latency, commit.
// ----------------------------------------------------------------------------
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.last_rd) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Entry memory, valid bits, scan trackers, replacement decision and result
// register.
// ----------------------------------------------------------------------------
module lfu_dp
   import lfu_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [63:0]         req_tdata,
   input  logic [0:0]          req_tuser,
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int USED_W = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (USED_W > CAP_BITS) ? USED_W : CAP_BITS;

   // entry memory: one write and one registered read per cycle
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [KEY_BITS-1:0]   data_mem  [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem   [ENTRIES];
   logic [KEY_BITS-1:0]   stamp_mem [ENTRIES];

   logic [ENTRIES-1:0]    valid_ff;
   logic [CAP_BITS-1:0]   capacity_ff;
   logic [KEY_BITS-1:0]   stamp_ff;

   // latched request
   logic                  func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   value_ff;
   logic [KEY_BITS-1:0]   now_ff;

   // scan pipeline
   logic [IDX_W-1:0]      scan_idx_ff;
   logic                  proc_vld_ff;
   logic [IDX_W-1:0]      proc_idx_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [KEY_BITS-1:0]   rd_data_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [KEY_BITS-1:0]   rd_stamp_ff;

   // scan trackers
   logic                  match_fnd_ff;
   logic [IDX_W-1:0]      match_idx_ff;
   logic [KEY_BITS-1:0]   match_data_ff;
   logic [COUNT_BITS-1:0] match_cnt_ff;
   logic                  vict_fnd_ff;
   logic [IDX_W-1:0]      vict_idx_ff;
   logic [KEY_BITS-1:0]   vict_key_ff;
   logic [COUNT_BITS-1:0] vict_cnt_ff;
   logic [KEY_BITS-1:0]   vict_age_ff;
   logic                  free_fnd_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic [USED_W-1:0]     used_ff;

   // result register
   logic                  rsp_vld_ff;
   logic                  hit_ff;
   logic                  evicted_ff;
   logic [KEY_BITS-1:0]   rd_val_ff;
   logic [KEY_BITS-1:0]   evk_ff;

   logic                  proc_valid;
   logic [KEY_BITS-1:0]   age;
   logic                  better;

   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      cap_eff;
   logic                  room;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [KEY_BITS-1:0]   wr_data;
   logic [COUNT_BITS-1:0] wr_cnt;
   logic [COUNT_BITS-1:0] match_cnt_inc;
   logic                  hit_in;
   logic                  evicted_in;
   logic [KEY_BITS-1:0]   rd_val_in;
   logic [KEY_BITS-1:0]   evk_in;

   assign sts.last_rd  = (scan_idx_ff == IDX_W'(ENTRIES - 1));
   assign sts.out_free = !rsp_vld_ff || rsp_tready;

   // ---------------- configuration and request latch ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         stamp_ff    <= '0;
      end else begin
         if (csr_we) capacity_ff <= csr_wdata;
         if (cmd.start) stamp_ff <= stamp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff  <= req_tuser[0];
         key_ff   <= req_tdata[31:0];
         value_ff <= req_tdata[63:32];
         now_ff   <= stamp_ff;
      end
   end

   // ---------------- memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_idx]   <= key_ff;
         data_mem[wr_idx]  <= wr_data;
         cnt_mem[wr_idx]   <= wr_cnt;
         stamp_mem[wr_idx] <= now_ff;
      end
      if (cmd.rd_en) begin
         rd_key_ff   <= key_mem[scan_idx_ff];
         rd_data_ff  <= data_mem[scan_idx_ff];
         rd_cnt_ff   <= cnt_mem[scan_idx_ff];
         rd_stamp_ff <= stamp_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // ---------------- scan ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         proc_vld_ff <= cmd.rd_en;
         if (cmd.start) begin
            scan_idx_ff <= '0;
         end else if (cmd.rd_en) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) proc_idx_ff <= scan_idx_ff;
   end

   assign proc_valid = proc_vld_ff && valid_ff[proc_idx_ff];
   assign age        = now_ff - rd_stamp_ff;
   // lower count wins; among equal counts the older entry wins
   assign better     = !vict_fnd_ff || (rd_cnt_ff < vict_cnt_ff) ||
                       ((rd_cnt_ff == vict_cnt_ff) && (age > vict_age_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         match_fnd_ff <= 1'b0;
         vict_fnd_ff  <= 1'b0;
         free_fnd_ff  <= 1'b0;
         used_ff      <= '0;
      end else if (cmd.start) begin
         match_fnd_ff <= 1'b0;
         vict_fnd_ff  <= 1'b0;
         free_fnd_ff  <= 1'b0;
         used_ff      <= '0;
      end else if (proc_vld_ff) begin
         if (proc_valid) begin
            used_ff <= used_ff + 1'b1;
            if (!match_fnd_ff && (rd_key_ff == key_ff)) match_fnd_ff <= 1'b1;
            if (better) vict_fnd_ff <= 1'b1;
         end else if (!free_fnd_ff) begin
            free_fnd_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc_vld_ff) begin
         if (proc_valid) begin
            if (!match_fnd_ff && (rd_key_ff == key_ff)) begin
               match_idx_ff  <= proc_idx_ff;
               match_data_ff <= rd_data_ff;
               match_cnt_ff  <= rd_cnt_ff;
            end
            if (better) begin
               vict_idx_ff <= proc_idx_ff;
               vict_key_ff <= rd_key_ff;
               vict_cnt_ff <= rd_cnt_ff;
               vict_age_ff <= age;
            end
         end else if (!free_fnd_ff) begin
            free_idx_ff <= proc_idx_ff;
         end
      end
   end

   // ---------------- decision ----------------
   assign cap_ext = CMP_W'(capacity_ff);
   assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign room    = (CMP_W'(used_ff) < cap_eff) && free_fnd_ff;
   assign match_cnt_inc = (match_cnt_ff == '1) ? match_cnt_ff : match_cnt_ff + 1'b1;

   always_comb begin
      wr_en      = 1'b0;
      wr_idx     = match_idx_ff;
      wr_data    = value_ff;
      wr_cnt     = match_cnt_inc;
      hit_in     = 1'b0;
      evicted_in = 1'b0;
      rd_val_in  = '0;
      evk_in     = '0;
      if (func_ff == FUNC_GET) begin
         if (match_fnd_ff) begin
            hit_in    = 1'b1;
            rd_val_in = match_data_ff;
            wr_en     = cmd.finish;
            wr_data   = match_data_ff;
         end
      end else if (capacity_ff != '0) begin
         if (match_fnd_ff) begin
            hit_in = 1'b1;
            wr_en  = cmd.finish;
         end else if (room) begin
            wr_en  = cmd.finish;
            wr_idx = free_idx_ff;
            wr_cnt = COUNT_BITS'(1);
         end else if (vict_fnd_ff) begin
            wr_en      = cmd.finish;
            wr_idx     = vict_idx_ff;
            wr_cnt     = COUNT_BITS'(1);
            evicted_in = 1'b1;
            evk_in     = vict_key_ff;
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         hit_ff     <= hit_in;
         evicted_ff <= evicted_in;
         rd_val_ff  <= rd_val_in;
         evk_ff     <= evk_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {evk_ff, rd_val_ff};
   assign rsp_tuser  = {evicted_ff, hit_ff};

endmodule

### hw/rtl/lfu_cache_key_value_store.sv
// ----------------------------------------------------------------------------
// lfu_cache_key_value_store
// Key-value store with least-frequently-used replacement, LRU tie break.
// ----------------------------------------------------------------------------
// Each request (get or put) passes through an accept state, a scan state that
// reads every entry of the entry memory in turn and compares key, use count
// and age, a drain state for the registered read, and a commit state that
// writes the entry back and loads the result register. One request is in
// flight at a time; a new request is accepted while the previous result
// still waits to be taken, and its commit then waits until that result is
// taken. The capacity register may be written only while the block is idle.
module lfu_cache_key_value_store
   import lfu_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,  // key[31:0], value[63:32]
   input  logic [0:0]          req_tuser,  // func[0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,  // read_value[31:0], evicted_key[63:32]
   output logic [1:0]          rsp_tuser,  // hit[0], evicted[1]
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata   // capacity
);

   cmd_type cmd;
   sts_type sts;

   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lfu_dp #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // busy right after an accepted transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a scan is running");

   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (req_tvalid && req_tready))
      else $error("scan started without an accepted transaction");

   // commit never overwrites a result that has not been taken
   a_finish_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && rsp_tvalid) |-> rsp_tready)
      else $error("result register overwritten");

endmodule

### tb/lfu_cache_key_value_store_tb.sv
// ----------------------------------------------------------------------------
// lfu_cache_key_value_store_tb
// Self-checking bench for the LFU key-value store. A queue-fed driver offers
// get/put transactions and a clocked monitor scores every response against a
// behavioral model of the store, with its own copy of entries, use counts,
// use stamps and capacity. The run covers directed corner cases, then random
// traffic under several capacities and back-pressure mixes.
// ----------------------------------------------------------------------------
module lfu_cache_key_value_store_tb
   import lfu_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES      = 16;
   localparam int COUNT_BITS   = 16;
   localparam int SETTLE       = 40;     // well past the latency of one request
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 230;
   localparam int POOL_SIZE    = 20;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic        func;
      logic [31:0] key;
      logic [31:0] value;
   } request_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } response_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata = '0;   // key[31:0], value[63:32]
   logic [0:0]          req_tuser = '0;   // func[0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [63:0]         rsp_tdata;        // read_value[31:0], evicted_key[63:32]
   logic [1:0]          rsp_tuser;        // hit[0], evicted[1]
   logic                csr_we = 1'b0;
   logic [CAP_BITS-1:0] csr_wdata = '0;   // capacity

   lfu_cache_key_value_store #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model of the store
   logic                  store_valid [ENTRIES];
   logic [31:0]           store_key   [ENTRIES];
   logic [31:0]           store_data  [ENTRIES];
   logic [COUNT_BITS-1:0] store_count [ENTRIES];
   logic [31:0]           store_stamp [ENTRIES];
   logic [31:0]           store_clock = '0;
   logic [CAP_BITS-1:0]   store_cap = CAPACITY_RESET;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   logic [31:0]  key_pool [POOL_SIZE];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;
   int  mismatches = 0;
   int  idle_cycles = 0;

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         store_valid[i] = 1'b0;
         store_key[i]   = '0;
         store_data[i]  = '0;
         store_count[i] = '0;
         store_stamp[i] = '0;
      end
   end

   function automatic void bump_entry(int slot, logic [31:0] now);
      if (store_count[slot] != '1)
         store_count[slot] = store_count[slot] + 1'b1;
      store_stamp[slot] = now;
   endfunction

   function automatic response_type lookup_and_update(request_type rq);
      response_type rs;
      logic [31:0]  now;
      int           cap;
      int           used;
      int           match;
      int           free_slot;
      int           victim;
      int           slot;
      rs        = '0;
      now       = store_clock;
      used      = 0;
      match     = -1;
      free_slot = -1;
      victim    = -1;
      store_clock = now + 32'd1;
      cap = (int'(store_cap) > ENTRIES) ? ENTRIES : int'(store_cap);

      for (int i = 0; i < ENTRIES; i++) begin
         if (store_valid[i]) begin
            used++;
            if (match < 0 && store_key[i] == rq.key)
               match = i;
            // lowest count wins, oldest use breaks ties, lowest slot after that
            if (victim < 0 || store_count[i] < store_count[victim] ||
                (store_count[i] == store_count[victim] &&
                 (now - store_stamp[i]) > (now - store_stamp[victim])))
               victim = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end

      if (rq.func == FUNC_GET) begin
         if (match >= 0) begin
            rs.hit        = 1'b1;
            rs.read_value = store_data[match];
            bump_entry(match, now);
         end
      end else if (cap != 0) begin
         if (match >= 0) begin
            rs.hit = 1'b1;
            store_data[match] = rq.value;
            bump_entry(match, now);
         end else begin
            if (used < cap && free_slot >= 0) begin
               slot = free_slot;
            end else begin
               slot = victim;
               if (slot >= 0) begin
                  rs.evicted     = 1'b1;
                  rs.evicted_key = store_key[slot];
               end
            end
            if (slot >= 0) begin
               store_valid[slot] = 1'b1;
               store_key[slot]   = rq.key;
               store_data[slot]  = rq.value;
               store_count[slot] = COUNT_BITS'(1);
               store_stamp[slot] = now;
            end
         end
      end
      return rs;
   endfunction

   // driver
   always @(negedge clock) begin
      request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            rq = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {rq.value, rq.key};
            req_tuser  <= rq.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      response_type got;
      response_type want;
      request_type  rq;
      bit           req_fire;
      bit           rsp_fire;
      if (!reset) begin
         req_fire = req_tvalid && req_tready;
         rsp_fire = rsp_tvalid && rsp_tready;

         // score first so a same-edge acceptance is never matched to itself
         if (rsp_fire) begin
            got.hit         = rsp_tuser[0];
            got.evicted     = rsp_tuser[1];
            got.read_value  = rsp_tdata[31:0];
            got.evicted_key = rsp_tdata[63:32];
            if (expected_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response: hit=%0b rd=%h ev=%0b evk=%h",
                           got.hit, got.read_value, got.evicted, got.evicted_key);
            end else begin
               want = expected_responses.pop_front();
               if (got.hit !== want.hit || got.read_value !== want.read_value ||
                   got.evicted !== want.evicted ||
                   got.evicted_key !== want.evicted_key) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"mismatch: exp hit=%0b rd=%h ev=%0b evk=%h",
                               " | got hit=%0b rd=%h ev=%0b evk=%h"},
                              want.hit, want.read_value, want.evicted, want.evicted_key,
                              got.hit, got.read_value, got.evicted, got.evicted_key);
               end
            end
         end

         if (req_fire) begin
            rq.func  = req_tuser[0];
            rq.key   = req_tdata[31:0];
            rq.value = req_tdata[63:32];
            expected_responses.push_back(lookup_and_update(rq));
            req_taken = 1'b1;
         end

         if (req_fire || rsp_fire)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[lfu_cache_key_value_store] ERROR");
            $finish;
         end
      end
   end

   task automatic add_request(logic func, logic [31:0] key, logic [31:0] value);
      request_type rq;
      rq.func  = func;
      rq.key   = key;
      rq.value = value;
      pending_requests.push_back(rq);
   endtask

   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      store_cap = cap;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_random_requests(int count);
      logic [31:0] key;
      logic [31:0] value;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            key = $urandom;
         case ($urandom_range(15))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = '1;
            default: value = $urandom;
         endcase
         add_request($urandom_range(1) ? FUNC_PUT : FUNC_GET, key, value);
      end
   endtask

   initial begin
      logic [CAP_BITS-1:0] phase_caps [8];
      phase_caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16};

      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset capacity: empty miss, extreme keys and values, update hit
      add_request(FUNC_GET, 32'h1234_5678, 32'h0);
      add_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      add_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      add_request(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      add_request(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      add_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
      add_request(FUNC_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
      add_request(FUNC_GET, 32'h0000_0000, 32'h0);
      wait_quiet();

      // capacity lowered below occupancy: each insert replaces one entry
      write_capacity(5'd2);
      add_request(FUNC_PUT, 32'd11, 32'd1);
      add_request(FUNC_PUT, 32'd22, 32'd2);
      add_request(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
      wait_quiet();

      // capacity zero: puts dropped, stored keys still readable
      write_capacity(5'd0);
      add_request(FUNC_PUT, 32'd33, 32'd3);
      add_request(FUNC_GET, 32'd22, 32'h0);
      add_request(FUNC_GET, 32'd33, 32'h0);
      wait_quiet();

      // capacity above the entry count saturates
      write_capacity(5'd31);
      for (int i = 0; i < 6; i++)
         add_request(FUNC_PUT, 32'd100 + i, $urandom);
      wait_quiet();

      // equal counts: least recently used goes first
      write_capacity(5'd1);
      add_request(FUNC_PUT, 32'd200, 32'hDEAD_BEEF);
      add_request(FUNC_GET, 32'd200, 32'h0);
      add_request(FUNC_GET, 32'd100, 32'h0);
      wait_quiet();

      for (int ph = 0; ph < 8; ph++) begin
         write_capacity(phase_caps[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         add_random_requests(PHASE_ITEMS);
         // sender keeps offering while the receiver backs off
         if (ph == 0)
            hold_request = 1'b1;
         wait_quiet();
      end

      if (mismatches == 0)
         $display("[lfu_cache_key_value_store] OK");
      else
         $display("[lfu_cache_key_value_store] ERROR");
      $finish;
   end

endmodule

### sim.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_dp.sv
hw/rtl/lfu_cache_key_value_store.sv
tb/lfu_cache_key_value_store_tb.sv
